// ----- rtl/core/held_lock_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the held lock table
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HELD_LOCK_TABLE_TOP_MACROS_SVH
`define HELD_LOCK_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge
`define HLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define HLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HLT_ASSERT(label, prop, msg)
`define HLT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/hlt_pkg.sv -----
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared sizes, status codes, datapath ops and status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hlt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int DEPTH_BITS  = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W    = 64;
  localparam int ID_W      = 64;
  localparam int ENTRIES_W = 5;
  localparam int HOLD_W    = 16;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = '1;
  localparam logic [CNT_W-1:0]      TABLE_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNHELD     = 3'd1,
    ST_REASSIGNED = 3'd2,
    ST_FULL       = 3'd3,
    ST_SATURATED  = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } command_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCAN,
    OP_INC,
    OP_APPEND,
    OP_FULL,
    OP_DEC,
    OP_MOVE_RD,
    OP_MOVE_WR,
    OP_MISS
  } op_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic is_release;
    logic depth_le1;
    logic depth_sat;
    logic full;
  } dp_stat_t;

  function automatic logic [ENTRIES_W-1:0] to_entries(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[ENTRIES_W-1:0];
  endfunction

  function automatic logic [HOLD_W-1:0] to_hold(input logic [DEPTH_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[HOLD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hlt_datapath.sv -----
// ----------------------------------------------------------------------------
// hlt_datapath
// Entry stores, pipelined id/address scan, entry update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "held_lock_table_top_macros.svh"

module hlt_datapath
  import hlt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire op_t                   op,
  input  wire logic                  in_command,
  input  wire logic [ADDR_W-1:0]     in_lock_addr,
  input  wire logic [ID_W-1:0]       in_lock_id,
  output dp_stat_t                   stat,
  output logic [2:0]                 res_status,
  output logic [ENTRIES_W-1:0]       res_entries,
  output logic [HOLD_W-1:0]          res_hold
);

  logic [ADDR_W-1:0]     mem_addr  [TABLE_DEPTH];
  logic [ID_W-1:0]       mem_ident [TABLE_DEPTH];
  logic [DEPTH_BITS-1:0] mem_depth [TABLE_DEPTH];

  logic                  is_rel_r;
  logic [ADDR_W-1:0]     key_addr_r;
  logic [ID_W-1:0]       key_id_r;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic                  hit_r, hit_nxt;
  logic                  addr_hit_r, addr_hit_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [DEPTH_BITS-1:0] pos_depth_r, pos_depth_nxt;

  logic [ADDR_W-1:0]     rd_addr_q;
  logic [ID_W-1:0]       rd_id_q;
  logic [DEPTH_BITS-1:0] rd_depth_q;

  status_t               res_status_r, res_status_nxt;
  logic [HOLD_W-1:0]     res_hold_r, res_hold_nxt;
  logic [ENTRIES_W-1:0]  res_entries_r;
  logic                  res_load;

  logic [CNT_W-1:0]      used_m1;
  logic [IDX_W-1:0]      rd_sel;
  logic                  issue;
  logic                  we_entry, we_depth;
  logic [IDX_W-1:0]      wr_idx;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ID_W-1:0]       wr_id;
  logic [DEPTH_BITS-1:0] wr_depth;
  logic                  hit_live;

  assign used_m1 = used_r - 1'b1;
  assign rd_sel  = (op == OP_MOVE_RD) ? used_m1[IDX_W-1:0] : rd_idx_r[IDX_W-1:0];
  assign issue   = (op == OP_SCAN) && !hit_r && (rd_idx_r < used_r);

  // hit_r holds over from the last beat until the next load
  assign hit_live = hit_r && (op != OP_IDLE) && (op != OP_LOAD);

  assign stat.done       = hit_r || (!cmp_vld_r && (rd_idx_r >= used_r));
  assign stat.hit        = hit_r;
  assign stat.is_release = is_rel_r;
  assign stat.depth_le1  = (pos_depth_r <= DEPTH_BITS'(1));
  assign stat.depth_sat  = (pos_depth_r == DEPTH_MAX);
  assign stat.full       = (used_r >= TABLE_FULL);

  // scan bookkeeping
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = 1'b0;
    hit_nxt       = hit_r;
    addr_hit_nxt  = addr_hit_r;
    pos_nxt       = pos_r;
    pos_depth_nxt = pos_depth_r;
    if (op == OP_LOAD) begin
      rd_idx_nxt   = '0;
      hit_nxt      = 1'b0;
      addr_hit_nxt = 1'b0;
    end else if (op == OP_SCAN) begin
      cmp_vld_nxt = issue;
      if (issue) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
      if (cmp_vld_r && !hit_r) begin
        if (rd_id_q == key_id_r) begin
          hit_nxt       = 1'b1;
          pos_nxt       = IDX_W'(rd_idx_r - 1'b1);
          pos_depth_nxt = rd_depth_q;
        end
        if (rd_addr_q == key_addr_r) begin
          addr_hit_nxt = 1'b1;
        end
      end
    end
  end

  // entry update and result
  always_comb begin
    used_nxt       = used_r;
    we_entry       = 1'b0;
    we_depth       = 1'b0;
    wr_idx         = pos_r;
    wr_addr        = key_addr_r;
    wr_id          = key_id_r;
    wr_depth       = pos_depth_r;
    res_load       = 1'b0;
    res_status_nxt = ST_OK;
    res_hold_nxt   = '0;
    unique case (op)
      OP_INC: begin
        we_depth       = 1'b1;
        wr_depth       = stat.depth_sat ? DEPTH_MAX : pos_depth_r + 1'b1;
        res_load       = 1'b1;
        res_status_nxt = stat.depth_sat ? ST_SATURATED : ST_OK;
        res_hold_nxt   = to_hold(wr_depth);
      end
      OP_APPEND: begin
        we_entry     = 1'b1;
        we_depth     = 1'b1;
        wr_idx       = used_r[IDX_W-1:0];
        wr_depth     = DEPTH_BITS'(1);
        used_nxt     = used_r + 1'b1;
        res_load     = 1'b1;
        res_hold_nxt = HOLD_W'(1);
      end
      OP_FULL: begin
        res_load       = 1'b1;
        res_status_nxt = ST_FULL;
      end
      OP_DEC: begin
        we_depth     = 1'b1;
        wr_depth     = pos_depth_r - 1'b1;
        res_load     = 1'b1;
        res_hold_nxt = to_hold(wr_depth);
      end
      OP_MOVE_WR: begin
        // last entry fills the freed slot
        we_entry = 1'b1;
        we_depth = 1'b1;
        wr_addr  = rd_addr_q;
        wr_id    = rd_id_q;
        wr_depth = rd_depth_q;
        used_nxt = used_m1;
        res_load = 1'b1;
      end
      OP_MISS: begin
        res_load       = 1'b1;
        res_status_nxt = addr_hit_r ? ST_REASSIGNED : ST_UNHELD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      rd_idx_r   <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      addr_hit_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      rd_idx_r   <= rd_idx_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      hit_r      <= hit_nxt;
      addr_hit_r <= addr_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      is_rel_r   <= (in_command == CMD_RELEASE);
      key_addr_r <= in_lock_addr;
      key_id_r   <= in_lock_id;
    end
    pos_r       <= pos_nxt;
    pos_depth_r <= pos_depth_nxt;
    if (res_load) begin
      res_status_r  <= res_status_nxt;
      res_hold_r    <= res_hold_nxt;
      res_entries_r <= to_entries(used_nxt);
    end
  end

  // entry stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_entry) begin
      mem_addr[wr_idx]  <= wr_addr;
      mem_ident[wr_idx] <= wr_id;
    end
    if (we_depth) begin
      mem_depth[wr_idx] <= wr_depth;
    end
    rd_addr_q  <= mem_addr[rd_sel];
    rd_id_q    <= mem_ident[rd_sel];
    rd_depth_q <= mem_depth[rd_sel];
  end

  assign res_status  = res_status_r;
  assign res_entries = res_entries_r;
  assign res_hold    = res_hold_r;

  `HLT_ASSERT(a_used_bound, used_r <= TABLE_FULL, "entry count beyond table depth")
  `HLT_ASSERT(a_append_room, (op == OP_APPEND) |-> (used_r < TABLE_FULL), "append into full table")
  `HLT_ASSERT(a_hit_in_range, hit_live |-> (CNT_W'(pos_r) < used_r), "hit position outside table")
  `HLT_ASSERT(a_move_nonempty, (op == OP_MOVE_RD) |-> (hit_r && used_r != '0), "move without hit")

endmodule

`default_nettype wire

// ----- rtl/core/hlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hlt_ctrl
// Sequencer: load, scan, then one update or a two-step remove-and-move.
// ----------------------------------------------------------------------------
`default_nettype none

`include "held_lock_table_top_macros.svh"

module hlt_ctrl
  import hlt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output op_t           op,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (stat.done) begin
          state_nxt = S_IDLE;
          priority if (!stat.is_release && stat.hit) begin
            op = OP_INC;
          end else if (!stat.is_release && stat.full) begin
            op = OP_FULL;
          end else if (!stat.is_release) begin
            op = OP_APPEND;
          end else if (stat.hit && stat.depth_le1) begin
            op        = OP_MOVE_RD;
            state_nxt = S_MOVE_WR;
          end else if (stat.hit) begin
            op = OP_DEC;
          end else begin
            op = OP_MISS;
          end
        end
      end
      S_MOVE_WR: begin
        op        = OP_MOVE_WR;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (op == OP_INC) || (op == OP_APPEND) || (op == OP_FULL) ||
                         (op == OP_DEC) || (op == OP_MOVE_WR) || (op == OP_MISS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `HLT_ASSERT(a_result_when_idle, out_valid_r |-> (state_r == S_IDLE), "result while busy")
  `HLT_ASSERT_NEXT(a_move_reports, state_r == S_MOVE_WR, out_valid_r, "remove gave no result")
  `HLT_ASSERT_NEXT(a_accept_scans, (state_r == S_IDLE) && start, state_r == S_SCAN, "start not taken")

endmodule

`default_nettype wire

// ----- rtl/core/held_lock_table_top.sv -----
// ----------------------------------------------------------------------------
// held_lock_table_top
// Reentrant held-lock set of one thread: acquire/release beats against a
// table of lock address, lock id and reentry count.
// ----------------------------------------------------------------------------
// Scan: all held entries are checked on a miss, up to the match on a hit;
//   a release that removes an entry adds a move-write step.
// Throughput: a new beat is taken only in idle, after the last result;
//   the scan reads one entry per cycle through the single registered
//   read port of the entry stores.
// Reset: rst_n (sync) empties the table; entry stores are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module held_lock_table_top
  import hlt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command beat
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_command,
  input  wire logic [ADDR_W-1:0]    in_lock_addr,
  input  wire logic [ID_W-1:0]      in_lock_id,
  // result beat
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [ENTRIES_W-1:0]      out_entries_in_use,
  output logic [HOLD_W-1:0]         out_hold_depth
);

  op_t      op;
  dp_stat_t stat;

  // Controller: IDLE takes the beat, SCAN walks the table until the id is
  // found or all held entries are checked, then issues one update op. A
  // release that drops the last hold reads the last entry and, in the next
  // cycle, writes it into the freed slot.
  hlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: entry stores with a registered read, a one-entry-per-cycle
  // compare pipeline for id and address, and the result registers. The
  // address match is gathered during the same pass, so a missed release
  // needs no second scan.
  hlt_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_command   (in_command),
    .in_lock_addr (in_lock_addr),
    .in_lock_id   (in_lock_id),
    .stat         (stat),
    .res_status   (out_status),
    .res_entries  (out_entries_in_use),
    .res_hold     (out_hold_depth)
  );

endmodule

`default_nettype wire
